/* hw/rtl/axis_angle_vector_rotation_assert.svh */
// Assertion macros for the rotation block
`ifndef AXIS_ANGLE_VECTOR_ROTATION_ASSERT_SVH
`define AXIS_ANGLE_VECTOR_ROTATION_ASSERT_SVH
`define AAVR_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define AAVR_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

/* hw/rtl/aavr_pkg.sv */
`timescale 1ns / 1ps
package aavr_pkg;
  localparam int CordicSteps = 16;
  localparam int SinCosW = 19;
  localparam logic signed [19:0] PiQ16 = 20'sd205887;
  localparam logic signed [19:0] HalfPiQ16 = 20'sd102944;
  localparam logic signed [SinCosW-1:0] CordicGain = 19'sd39797;

  // func codes
  localparam logic FuncAxis = 1'b0;
  localparam logic FuncEuler = 1'b1;

  // side data carried beside each rotation unit: func, pad, angle_y, angle_z
  localparam int TagW = 1 + 1 + 32;
  // side data through the CORDIC: tag, vector and axis
  localparam int CordicTagW = TagW + 3*32 + 3*16;
  // register stages of one rotation unit: fold, 8 CORDIC, 4 arithmetic
  localparam int RotLat = 1 + CordicSteps / 2 + 4;

  typedef struct packed {
    logic               func;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
  } out_word_t;

  function automatic logic signed [19:0] atan_q16(input int i);
    case (i)
      0: atan_q16 = 20'sd51472;
      1: atan_q16 = 20'sd30386;
      2: atan_q16 = 20'sd16055;
      3: atan_q16 = 20'sd8150;
      4: atan_q16 = 20'sd4091;
      5: atan_q16 = 20'sd2047;
      6: atan_q16 = 20'sd1024;
      7: atan_q16 = 20'sd512;
      8: atan_q16 = 20'sd256;
      9: atan_q16 = 20'sd128;
      10: atan_q16 = 20'sd64;
      11: atan_q16 = 20'sd32;
      12: atan_q16 = 20'sd16;
      13: atan_q16 = 20'sd8;
      14: atan_q16 = 20'sd4;
      15: atan_q16 = 20'sd2;
      default: atan_q16 = 20'sd0;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction
endpackage

/* hw/rtl/aavr_cordic.sv */
`timescale 1ns / 1ps
// Pipelined sine/cosine: fold stage, then two CORDIC steps per stage
module aavr_cordic (
  input  logic clk,
  input  logic en,
  input  logic signed [15:0] angle,
  input  logic [aavr_pkg::CordicTagW-1:0] tag_in,
  output logic signed [aavr_pkg::SinCosW-1:0] sn,
  output logic signed [aavr_pkg::SinCosW-1:0] cs,
  output logic [aavr_pkg::CordicTagW-1:0] tag_out
);
  import aavr_pkg::*;
  localparam int NSt = CordicSteps / 2;
  logic signed [SinCosW-1:0] x [NSt+1];
  logic signed [SinCosW-1:0] y [NSt+1];
  logic signed [19:0] z [NSt+1];
  logic flip [NSt+1];
  logic [CordicTagW-1:0] tg [NSt+1];
  logic signed [19:0] zw;

  // angle fold into +/- pi/2
  assign zw = {{1{angle[15]}}, angle, 3'b000};
  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= CordicGain;
      y[0] <= '0;
      tg[0] <= tag_in;
      if (zw > HalfPiQ16) begin
        z[0] <= zw - PiQ16; flip[0] <= 1'b1;
      end else if (zw < -HalfPiQ16) begin
        z[0] <= zw + PiQ16; flip[0] <= 1'b1;
      end else begin
        z[0] <= zw; flip[0] <= 1'b0;
      end
    end
  end

  for (genvar s = 0; s < NSt; s++) begin : g_st
    logic signed [SinCosW-1:0] xa, ya, xb, yb;
    logic signed [19:0] za, zb;
    always_comb begin
      if (z[s] >= 0) begin
        xa = x[s] - (y[s] >>> (2*s)); ya = y[s] + (x[s] >>> (2*s));
        za = z[s] - atan_q16(2*s);
      end else begin
        xa = x[s] + (y[s] >>> (2*s)); ya = y[s] - (x[s] >>> (2*s));
        za = z[s] + atan_q16(2*s);
      end
      if (za >= 0) begin
        xb = xa - (ya >>> (2*s+1)); yb = ya + (xa >>> (2*s+1));
        zb = za - atan_q16(2*s+1);
      end else begin
        xb = xa + (ya >>> (2*s+1)); yb = ya - (xa >>> (2*s+1));
        zb = za + atan_q16(2*s+1);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x[s+1] <= xb; y[s+1] <= yb; z[s+1] <= zb;
        flip[s+1] <= flip[s]; tg[s+1] <= tg[s];
      end
    end
  end

  assign cs = flip[NSt] ? -x[NSt] : x[NSt];
  assign sn = flip[NSt] ? -y[NSt] : y[NSt];
  assign tag_out = tg[NSt];
endmodule

/* hw/rtl/aavr_rotate.sv */
`timescale 1ns / 1ps
// One rotation: sin/cos, matrix build, products, sum and saturate
module aavr_rotate (
  input  logic clk,
  input  logic en,
  input  logic signed [31:0] vin [3],
  input  logic signed [15:0] ax [3],
  input  logic signed [15:0] angle,
  input  logic [aavr_pkg::TagW-1:0] tag_in,
  output logic signed [31:0] vout [3],
  output logic [aavr_pkg::TagW-1:0] tag_out
);
  import aavr_pkg::*;
  logic [CordicTagW-1:0] d_in, d_c;
  logic signed [SinCosW-1:0] sn, cs;
  logic signed [31:0] v1 [3];
  logic signed [15:0] a1 [3];
  logic [TagW-1:0] t1;

  assign d_in = {tag_in, vin[0], vin[1], vin[2], ax[0], ax[1], ax[2]};
  aavr_cordic u_cordic (
    .clk(clk), .en(en), .angle(angle), .tag_in(d_in),
    .sn(sn), .cs(cs), .tag_out(d_c)
  );
  assign {t1, v1[0], v1[1], v1[2], a1[0], a1[1], a1[2]} = d_c;

  // stage A: axis products and s*a
  logic signed [SinCosW-1:0] cA;
  logic signed [32:0] aa [3][3];
  logic signed [35:0] sa [3];
  logic signed [31:0] vA [3];
  logic [TagW-1:0] tA;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) aa[i][j] <= 33'(a1[i] * a1[j]);
        sa[i] <= 36'(sn * a1[i]);
        vA[i] <= v1[i];
      end
      cA <= cs; tA <= t1;
    end
  end

  // stage B: matrix entries
  logic signed [SinCosW:0] omc;
  logic signed [52:0] pr [3][3];
  logic signed [23:0] sk [3];
  logic signed [23:0] m_next [3][3];
  logic signed [23:0] m [3][3];
  logic signed [31:0] vB [3];
  logic [TagW-1:0] tB;
  assign omc = 20'sd65536 - SinCosW'(cA);
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sk[i] = 24'(sa[i] >>> 14);
      for (int j = 0; j < 3; j++) begin
        pr[i][j] = 53'(omc * aa[i][j]);
        m_next[i][j] = 24'(pr[i][j] >>> 28);
      end
      m_next[i][i] = m_next[i][i] + 24'(cA);
    end
    // skew-symmetric sine terms
    m_next[0][1] = m_next[0][1] - sk[2];
    m_next[1][0] = m_next[1][0] + sk[2];
    m_next[0][2] = m_next[0][2] + sk[1];
    m_next[2][0] = m_next[2][0] - sk[1];
    m_next[1][2] = m_next[1][2] - sk[0];
    m_next[2][1] = m_next[2][1] + sk[0];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m <= m_next;
      vB <= vA;
      tB <= tA;
    end
  end

  // stage C: products
  logic signed [55:0] p [3][3];
  logic [TagW-1:0] tC;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) p[i][j] <= 56'(m[i][j] * vB[j]);
      tC <= tB;
    end
  end

  // stage D: sum, round, saturate
  logic signed [57:0] acc [3];
  always_comb begin
    for (int i = 0; i < 3; i++)
      acc[i] = 58'(p[i][0]) + 58'(p[i][1]) + 58'(p[i][2]) + 58'sd32768;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) vout[i] <= sat32(64'(acc[i] >>> 16));
      tag_out <= tC;
    end
  end
endmodule

/* hw/rtl/axis_angle_vector_rotation.sv */
`timescale 1ns / 1ps
// Rodrigues / Euler rotation of a Q16.16 vector.
// Input channel in_valid/in_stall/in_data carries one word per item; output
// channel out_valid/out_stall/out_data returns one rotated word per item.
// func 0 rotates about the given axis by angle_x; func 1 rotates about X, Y
// and Z in turn. Three rotation units are chained; in mode 0 delay lines
// beside the later units carry the first unit's result straight through.
// Each rotation unit is 13 register stages (fold, 8 CORDIC, 4 arithmetic);
// the third unit is followed by the output register.
// Throughput is one word per cycle unless stalled. The whole pipe advances
// only when the output register is empty or being taken; in_stall is
// out_stall gated by output occupancy, so a stall freezes all stages and
// loses nothing. Reset clears the valid bits; payload stages are not reset.
module axis_angle_vector_rotation (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  aavr_pkg::in_word_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output aavr_pkg::out_word_t out_data
);
  import aavr_pkg::*;
  logic en;
  logic [3*RotLat-1:0] vld;
  assign en = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[3*RotLat-2:0], in_valid};
  end

  logic signed [31:0] v0 [3], v1 [3], v2 [3], v3 [3], w1 [3], w2 [3];
  logic signed [15:0] a0 [3], ux [3], uy [3], uz [3];
  logic [TagW-1:0] t0, t1, t2, t3;
  assign v0 = '{in_data.vec_x, in_data.vec_y, in_data.vec_z};
  assign ux = '{16'sd16384, 16'sd0, 16'sd0};
  assign uy = '{16'sd0, 16'sd16384, 16'sd0};
  assign uz = '{16'sd0, 16'sd0, 16'sd16384};
  // first unit turns about unit X in Euler mode
  always_comb begin
    if (in_data.func == FuncEuler) a0 = ux;
    else a0 = '{in_data.axis_x, in_data.axis_y, in_data.axis_z};
  end
  assign t0 = {in_data.func, 1'b0, in_data.angle_y, in_data.angle_z};

  aavr_rotate u_r0 (.clk(clk), .en(en), .vin(v0), .ax(a0),
    .angle(in_data.angle_x), .tag_in(t0), .vout(v1), .tag_out(t1));
  aavr_rotate u_r1 (.clk(clk), .en(en), .vin(v1), .ax(uy),
    .angle(t1[31:16]), .tag_in(t1), .vout(w1), .tag_out(t2));
  // mode 0 carries the first result past the later units in delay lines
  logic [3*32-1:0] hold1, hold2;
  logic [3*32-1:0] dly1 [RotLat], dly2 [RotLat];
  always_ff @(posedge clk) begin
    if (en) begin
      dly1[0] <= {v1[0], v1[1], v1[2]};
      for (int i = 1; i < RotLat; i++) dly1[i] <= dly1[i-1];
    end
  end
  assign hold1 = dly1[RotLat-1];
  always_comb begin
    for (int i = 0; i < 3; i++)
      v2[i] = (t2[TagW-1] == FuncEuler) ? w1[i] : hold1[32*(2-i) +: 32];
  end
  aavr_rotate u_r2 (.clk(clk), .en(en), .vin(v2), .ax(uz),
    .angle(t2[15:0]), .tag_in(t2), .vout(w2), .tag_out(t3));
  always_ff @(posedge clk) begin
    if (en) begin
      dly2[0] <= {v2[0], v2[1], v2[2]};
      for (int i = 1; i < RotLat; i++) dly2[i] <= dly2[i-1];
    end
  end
  assign hold2 = dly2[RotLat-1];
  always_comb begin
    for (int i = 0; i < 3; i++)
      v3[i] = (t3[TagW-1] == FuncEuler) ? w2[i] : hold2[32*(2-i) +: 32];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vld[3*RotLat-1];
  end
  always_ff @(posedge clk) begin
    if (en) out_data <= '{rot_x: v3[0], rot_y: v3[1], rot_z: v3[2]};
  end

`include "axis_angle_vector_rotation_assert.svh"
  `AAVR_ASSERT_IMP(a_stall_only_full, in_stall, out_valid && out_stall)
  `AAVR_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `AAVR_ASSERT_NXT(a_frozen_pipe, out_valid && out_stall, $stable(vld))
endmodule
